/* rtl/bbc_pkg.sv */
// bbc_pkg: shared types and codes for the block buffer cache engine
// used by bbc_front, bbc_back and block_buffer_cache_lru_core
`timescale 1ns / 1ps

package bbc_pkg;

    localparam logic [2:0] KIND_GET   = 3'd0;
    localparam logic [2:0] KIND_PUT   = 3'd1;
    localparam logic [2:0] KIND_DIRTY = 3'd2;
    localparam logic [2:0] KIND_SYNC  = 3'd3;
    localparam logic [2:0] KIND_PURGE = 3'd4;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_FILL     = 3'd1;
    localparam logic [2:0] ST_WB       = 3'd2;
    localparam logic [2:0] ST_ALL_BUSY = 3'd3;
    localparam logic [2:0] ST_NOT_BUSY = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam int SYNC_LIMIT = 32;

    typedef enum logic [2:0] {
        OP_GET   = 3'd0,
        OP_PUT   = 3'd1,
        OP_DIRTY = 3'd2,
        OP_SYNC  = 3'd3,
        OP_PURGE = 3'd4,
        OP_NOP   = 3'd5
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  dev;
        logic [31:0] addr;
        logic [4:0]  idx;
        logic        idx_bad;
    } t_req;

endpackage

/* rtl/bbc_front.sv */
// bbc_front: accepts requests, decodes the kind and range-checks the index
// holds a two-deep queue toward bbc_back; depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_front #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_kind,
    input  logic [3:0]    i_device_id,
    input  logic [31:0]   i_block_address,
    input  logic [4:0]    i_buffer_index,
    output logic          o_req_valid,
    output bbc_pkg::t_req o_req,
    input  logic          i_req_pop
);

    bbc_pkg::t_req r_q [2];
    bbc_pkg::t_req n_req;
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    always_comb begin
        n_req.dev     = i_device_id;
        n_req.addr    = i_block_address;
        n_req.idx     = i_buffer_index;
        n_req.idx_bad = ({1'b0, i_buffer_index} >= 6'(NUM_ENTRIES));
        unique case (i_kind)
            bbc_pkg::KIND_GET:   n_req.op = bbc_pkg::OP_GET;
            bbc_pkg::KIND_PUT:   n_req.op = bbc_pkg::OP_PUT;
            bbc_pkg::KIND_DIRTY: n_req.op = bbc_pkg::OP_DIRTY;
            bbc_pkg::KIND_SYNC:  n_req.op = bbc_pkg::OP_SYNC;
            bbc_pkg::KIND_PURGE: n_req.op = bbc_pkg::OP_PURGE;
            default:             n_req.op = bbc_pkg::OP_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_req_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_req_pop);
        end
    end

endmodule

/* rtl/bbc_back.sv */
// bbc_back: tag store, busy counts, dirty marks and recency ranks
// runs one request at a time and drives the result register; depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_back #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  bbc_pkg::t_req i_req,
    output logic          o_req_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_status,
    output logic [4:0]    o_entry_index,
    output logic [3:0]    o_out_device,
    output logic [31:0]   o_out_address,
    output logic          o_last
);

    localparam int IW = $clog2(NUM_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DISP = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_PICK = 7'b0001000,
        S_FILL = 7'b0010000,
        S_SYNC = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    bbc_pkg::t_req r_req;

    logic        r_tv   [NUM_ENTRIES], n_tv   [NUM_ENTRIES];
    logic [3:0]  r_td   [NUM_ENTRIES], n_td   [NUM_ENTRIES];
    logic [31:0] r_ta   [NUM_ENTRIES], n_ta   [NUM_ENTRIES];
    logic [7:0]  r_busy [NUM_ENTRIES], n_busy [NUM_ENTRIES];
    logic        r_dirty[NUM_ENTRIES], n_dirty[NUM_ENTRIES];
    logic [IW-1:0] r_rank [NUM_ENTRIES], n_rank [NUM_ENTRIES];

    logic [IW-1:0] r_i, n_i, r_vic, n_vic, r_best, n_best;
    logic          r_found, n_found;
    logic [5:0]    r_cnt, n_cnt;

    logic        r_ov, n_ov, r_last, n_last;
    logic [2:0]  r_st, n_st;
    logic [4:0]  r_ei, n_ei;
    logic [3:0]  r_od, n_od;
    logic [31:0] r_oa, n_oa;

    logic          w_free, w_hit;
    logic [IW-1:0] w_hit_idx, w_e;

    assign w_free = !r_ov || i_ready;
    assign w_e    = IW'(r_req.idx);

    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int k = NUM_ENTRIES - 1; k >= 0; k--) begin
            if (r_tv[k] && r_td[k] == r_req.dev && r_ta[k] == r_req.addr) begin
                w_hit     = 1'b1;
                w_hit_idx = IW'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_tv = r_tv; n_td = r_td; n_ta = r_ta;
        n_busy = r_busy; n_dirty = r_dirty; n_rank = r_rank;
        n_i = r_i; n_vic = r_vic; n_best = r_best; n_found = r_found; n_cnt = r_cnt;
        n_ov = r_ov && !i_ready;
        n_st = r_st; n_ei = r_ei; n_od = r_od; n_oa = r_oa; n_last = r_last;
        o_req_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_req.op)
                    bbc_pkg::OP_GET: begin
                        if (!w_hit) begin
                            n_i = '0; n_found = 1'b0; n_best = '0;
                            n_state = S_SCAN;
                        end else if (w_free) begin
                            if (r_busy[w_hit_idx] != 8'hFF)
                                n_busy[w_hit_idx] = r_busy[w_hit_idx] + 8'd1;
                            n_ov = 1'b1; n_st = bbc_pkg::ST_HIT; n_ei = 5'(w_hit_idx);
                            n_od = r_req.dev; n_oa = r_req.addr; n_last = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    bbc_pkg::OP_PUT, bbc_pkg::OP_DIRTY: begin
                        if (w_free) begin
                            n_ov = 1'b1; n_ei = r_req.idx; n_od = '0; n_oa = '0;
                            n_last = 1'b1; n_state = S_IDLE;
                            if (r_req.idx_bad || r_busy[w_e] == 8'd0) begin
                                n_st = bbc_pkg::ST_NOT_BUSY;
                            end else begin
                                n_st = bbc_pkg::ST_DONE;
                                if (r_req.op == bbc_pkg::OP_DIRTY) begin
                                    n_dirty[w_e] = 1'b1;
                                end else begin
                                    n_busy[w_e] = r_busy[w_e] - 8'd1;
                                    for (int k = 0; k < NUM_ENTRIES; k++)
                                        if (r_rank[k] < r_rank[w_e])
                                            n_rank[k] = r_rank[k] + 1'b1;
                                    n_rank[w_e] = '0;
                                end
                            end
                        end
                    end
                    bbc_pkg::OP_SYNC: begin
                        n_i = '0; n_cnt = '0; n_state = S_SYNC;
                    end
                    bbc_pkg::OP_PURGE: begin
                        for (int k = 0; k < NUM_ENTRIES; k++) begin
                            if (r_td[k] == r_req.dev) n_busy[k] = 8'd0;
                            n_tv[k] = 1'b0;
                        end
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (r_busy[r_i] == 8'd0 && (!r_found || r_rank[r_i] > r_best)) begin
                    n_found = 1'b1; n_best = r_rank[r_i]; n_vic = r_i;
                end
                n_i = r_i + 1'b1;
                if (r_i == IW'(NUM_ENTRIES - 1)) n_state = S_PICK;
            end
            S_PICK: begin
                if (!r_found) begin
                    if (w_free) begin
                        n_ov = 1'b1; n_st = bbc_pkg::ST_ALL_BUSY; n_ei = '0;
                        n_od = '0; n_oa = '0; n_last = 1'b1; n_state = S_IDLE;
                    end
                end else if (!r_dirty[r_vic]) begin
                    n_state = S_FILL;
                end else if (w_free) begin
                    n_ov = 1'b1; n_st = bbc_pkg::ST_WB; n_ei = 5'(r_vic);
                    n_od = r_td[r_vic]; n_oa = r_ta[r_vic]; n_last = 1'b0;
                    n_dirty[r_vic] = 1'b0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (w_free) begin
                    n_tv[r_vic] = 1'b1; n_td[r_vic] = r_req.dev;
                    n_ta[r_vic] = r_req.addr; n_busy[r_vic] = 8'd1;
                    n_ov = 1'b1; n_st = bbc_pkg::ST_FILL; n_ei = 5'(r_vic);
                    n_od = r_req.dev; n_oa = r_req.addr; n_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SYNC: begin
                if (r_dirty[r_i] && r_cnt < 6'(bbc_pkg::SYNC_LIMIT)) begin
                    if (w_free) begin
                        n_ov = 1'b1; n_st = bbc_pkg::ST_WB; n_ei = 5'(r_i);
                        n_od = r_td[r_i]; n_oa = r_ta[r_i]; n_last = 1'b0;
                        n_dirty[r_i] = 1'b0; n_cnt = r_cnt + 6'd1;
                        n_i = r_i + 1'b1;
                        if (r_i == IW'(NUM_ENTRIES - 1)) n_state = S_DONE;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                    if (r_i == IW'(NUM_ENTRIES - 1)) n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_free) begin
                    n_ov = 1'b1; n_st = bbc_pkg::ST_DONE; n_ei = '0;
                    n_od = '0; n_oa = '0; n_last = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) r_req <= i_req;
        r_td <= n_td; r_ta <= n_ta;
        r_i <= n_i; r_vic <= n_vic; r_best <= n_best; r_cnt <= n_cnt;
        r_st <= n_st; r_ei <= n_ei; r_od <= n_od; r_oa <= n_oa; r_last <= n_last;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                r_tv[k]    <= 1'b0;
                r_busy[k]  <= 8'd0;
                r_dirty[k] <= 1'b0;
                r_rank[k]  <= IW'(k);
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_found <= n_found;
            r_tv    <= n_tv;
            r_busy  <= n_busy;
            r_dirty <= n_dirty;
            r_rank  <= n_rank;
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_st;
    assign o_entry_index = r_ei;
    assign o_out_device  = r_od;
    assign o_out_address = r_oa;
    assign o_last        = r_last;

endmodule

/* rtl/block_buffer_cache_lru_core.sv */
// block_buffer_cache_lru_core: top level of the buffer cache tag engine
// instantiates bbc_front and bbc_back; depends on bbc_pkg
//
//   channel   handshake            payload
//   request   i_valid / o_ready    i_kind i_device_id i_block_address i_buffer_index
//   result    o_valid / i_ready    o_status o_entry_index o_out_device o_out_address o_last
//
// put, dirty, get hit: result from the dispatch state; purge and unknown kinds: via the done state
// get miss: the one-entry-a-cycle victim scan, then the pick state (write-back of a dirty victim) and fill
// sync: walks the entries in order and writes back the dirty ones
// synchronous active-low reset; no clearing pass; either side may stall at any time
`timescale 1ns / 1ps

module block_buffer_cache_lru_core #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_device_id,
    input  logic [31:0] i_block_address,
    input  logic [4:0]  i_buffer_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [4:0]  o_entry_index,
    output logic [3:0]  o_out_device,
    output logic [31:0] o_out_address,
    output logic        o_last
);

    logic          w_req_valid, w_req_pop;
    bbc_pkg::t_req w_req;

    bbc_front #(.NUM_ENTRIES(NUM_ENTRIES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_device_id(i_device_id),
        .i_block_address(i_block_address), .i_buffer_index(i_buffer_index),
        .o_req_valid(w_req_valid), .o_req(w_req), .i_req_pop(w_req_pop)
    );

    bbc_back #(.NUM_ENTRIES(NUM_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(w_req_valid), .i_req(w_req), .o_req_pop(w_req_pop),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_entry_index(o_entry_index),
        .o_out_device(o_out_device), .o_out_address(o_out_address),
        .o_last(o_last)
    );

endmodule
